@@ hw/rtl/cvcc_pkg.sv @@
package cvcc_pkg;

    // Field widths
    localparam int MV_W       = 16;
    localparam int GAIN_W     = 24;
    localparam int FRAC_BITS  = 16;
    localparam int ERR_W      = MV_W + 2;
    localparam int PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int INTEG_W    = MV_W + FRAC_BITS + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    // Loop constants
    localparam int VOLTAGE_OFFSET_MV  = 5;
    localparam int CURRENT_OUT_MIN_MV = -10000;
    localparam int CV_HEADROOM_MV     = 2000;
    localparam int CURRENT_INTEG_RST_MV = 36500;

    typedef logic        [MV_W-1:0]    mv_t;
    typedef logic        [GAIN_W-1:0]  gain_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [INTEG_W-1:0] integ_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLTAGE_KP          = 3'd0,
        CFG_VOLTAGE_KI          = 3'd1,
        CFG_CURRENT_KP          = 3'd2,
        CFG_CURRENT_KI          = 3'd3,
        CFG_VOLTAGE_DEADBAND    = 3'd4,
        CFG_CURRENT_DEADBAND    = 3'd5,
        CFG_VOLTAGE_TRIM_LIMIT  = 3'd6,
        CFG_CURRENT_OUT_MAX     = 3'd7
    } cfg_idx_t;

    // Register reset values
    localparam gain_t VOLTAGE_KP_RST          = gain_t'(328);
    localparam gain_t VOLTAGE_KI_RST          = gain_t'(655);
    localparam gain_t CURRENT_KP_RST          = gain_t'(32768);
    localparam gain_t CURRENT_KI_RST          = gain_t'(32768);
    localparam mv_t   VOLTAGE_DEADBAND_RST    = mv_t'(15);
    localparam mv_t   CURRENT_DEADBAND_RST    = mv_t'(2);
    localparam mv_t   VOLTAGE_TRIM_LIMIT_RST  = mv_t'(2000);
    localparam mv_t   CURRENT_OUT_MAX_RST     = mv_t'(36500);

    localparam acc_t CMIN_Q =
        acc_t'(longint'(CURRENT_OUT_MIN_MV) * (longint'(1) << FRAC_BITS));
    localparam acc_t HEADROOM_Q =
        acc_t'(longint'(CV_HEADROOM_MV) * (longint'(1) << FRAC_BITS));
    localparam integ_t CURRENT_INTEG_RST_Q =
        integ_t'(longint'(CURRENT_INTEG_RST_MV) * (longint'(1) << FRAC_BITS));

    // Whole millivolts to signed fixed point
    function automatic acc_t mv_to_q(input mv_t mv);
        return acc_t'({{(ACC_W-MV_W-FRAC_BITS){1'b0}}, mv, {FRAC_BITS{1'b0}}});
    endfunction

    function automatic acc_t clamp_acc(input acc_t v, input acc_t lo, input acc_t hi);
        acc_t r;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Zero the error when its magnitude is below the deadband
    function automatic err_t deadband_err(input err_t e, input mv_t db);
        logic [ERR_W-1:0] mag;
        mag = (e < 0) ? ERR_W'(-e) : ERR_W'(e);
        return (mag < ERR_W'(db)) ? '0 : e;
    endfunction

    // Unsigned gain times signed error, exact
    function automatic prod_t gain_mul(input gain_t g, input err_t e);
        return prod_t'($signed({1'b0, g})) * prod_t'(e);
    endfunction

endpackage

@@ hw/rtl/cvcc_tick_if.sv @@
interface cvcc_tick_if;
    import cvcc_pkg::*;

    logic valid;
    logic ready;
    mv_t  set_voltage_mv;
    mv_t  set_current_ma;
    mv_t  measured_voltage_mv;
    mv_t  measured_current_ma;
    logic output_enable;
    logic setpoint_changed;

    modport source (
        output valid, set_voltage_mv, set_current_ma, measured_voltage_mv,
               measured_current_ma, output_enable, setpoint_changed,
        input  ready
    );

    modport sink (
        input  valid, set_voltage_mv, set_current_ma, measured_voltage_mv,
               measured_current_ma, output_enable, setpoint_changed,
        output ready
    );
endinterface

@@ hw/rtl/cvcc_result_if.sv @@
interface cvcc_result_if;
    import cvcc_pkg::*;

    logic valid;
    logic ready;
    mv_t  voltage_cmd_mv;
    logic target_valid;
    logic regulation_mode;
    logic drive_enable;
    logic drive_enable_changed;

    modport source (
        output valid, voltage_cmd_mv, target_valid, regulation_mode, drive_enable,
               drive_enable_changed,
        input  ready
    );

    modport sink (
        input  valid, voltage_cmd_mv, target_valid, regulation_mode, drive_enable,
               drive_enable_changed,
        output ready
    );
endinterface

@@ hw/rtl/cv_cc_dual_pi_regulator.sv @@
// Channel  Dir  Handshake      Payload
// -------  ---  -------------  -------------------------------------------------
// tick     in   valid / ready  setpoints, measurements, enable, setpoint change
// result   out  valid / ready  command mV, target valid, mode, drive enable/edge
// wr_*     in   wr_en only     register index and data, no read-back
//
// One tick per clock unless result.ready stalls the pipeline; a tick's result is
// presented from the result register after the input and gain product registers.
// The integrator update, CV/CC compare and tracking clamp run combinationally from
// the product register into the result register, which sets the one-tick rate.
// rst_n clears pipeline valids, resets loop state and registers; no clearing pass.
// While a result waits on result.ready up to two more ticks transfer, then tick.ready drops.
module cv_cc_dual_pi_regulator (
    input  logic                              clk,
    input  logic                              rst_n,
    cvcc_tick_if.sink                         tick,
    cvcc_result_if.source                     result,
    input  logic                              wr_en,
    input  logic [cvcc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [cvcc_pkg::CFG_DATA_W-1:0]   wr_data
);
    import cvcc_pkg::*;

    typedef struct packed {
        mv_t  set_voltage_mv;
        mv_t  set_current_ma;
        mv_t  measured_voltage_mv;
        mv_t  measured_current_ma;
        logic output_enable;
        logic setpoint_changed;
    } tick_t;

    typedef struct packed {
        mv_t   set_voltage_mv;
        logic  output_enable;
        logic  setpoint_changed;
        prod_t v_p;
        prod_t v_i;
        prod_t c_p;
        prod_t c_i;
    } prod_stage_t;

    typedef struct packed {
        mv_t  voltage_cmd_mv;
        logic target_valid;
        logic regulation_mode;
        logic drive_enable;
        logic drive_enable_changed;
    } result_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    gain_t voltage_kp_reg;
    gain_t voltage_ki_reg;
    gain_t current_kp_reg;
    gain_t current_ki_reg;
    mv_t   voltage_deadband_mv_reg;
    mv_t   current_deadband_ma_reg;
    mv_t   voltage_trim_limit_mv_reg;
    mv_t   current_out_max_mv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_kp_reg            <= VOLTAGE_KP_RST;
            voltage_ki_reg            <= VOLTAGE_KI_RST;
            current_kp_reg            <= CURRENT_KP_RST;
            current_ki_reg            <= CURRENT_KI_RST;
            voltage_deadband_mv_reg   <= VOLTAGE_DEADBAND_RST;
            current_deadband_ma_reg   <= CURRENT_DEADBAND_RST;
            voltage_trim_limit_mv_reg <= VOLTAGE_TRIM_LIMIT_RST;
            current_out_max_mv_reg    <= CURRENT_OUT_MAX_RST;
        end
        else if (wr_en)
        begin
            // 16-bit registers take the low bits of the write data
            case (cfg_idx_t'(wr_index))
                CFG_VOLTAGE_KP:         voltage_kp_reg            <= wr_data;
                CFG_VOLTAGE_KI:         voltage_ki_reg            <= wr_data;
                CFG_CURRENT_KP:         current_kp_reg            <= wr_data;
                CFG_CURRENT_KI:         current_ki_reg            <= wr_data;
                CFG_VOLTAGE_DEADBAND:   voltage_deadband_mv_reg   <= wr_data[MV_W-1:0];
                CFG_CURRENT_DEADBAND:   current_deadband_ma_reg   <= wr_data[MV_W-1:0];
                CFG_VOLTAGE_TRIM_LIMIT: voltage_trim_limit_mv_reg <= wr_data[MV_W-1:0];
                CFG_CURRENT_OUT_MAX:    current_out_max_mv_reg    <= wr_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage loads when it is empty or the stage
    // after it is loading this cycle.
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        res_valid_reg;
    tick_t       s1_reg;
    prod_stage_t s2_reg;
    result_t     res_reg;

    logic load_res;
    logic load_s2;
    logic load_s1;

    assign load_res   = s2_valid_reg && (!res_valid_reg || result.ready);
    assign load_s2    = s1_valid_reg && (!s2_valid_reg || load_res);
    assign tick.ready = !s1_valid_reg || load_s2;
    assign load_s1    = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (load_s2)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (load_s2)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (load_res)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the tick
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_reg.set_voltage_mv      <= tick.set_voltage_mv;
            s1_reg.set_current_ma      <= tick.set_current_ma;
            s1_reg.measured_voltage_mv <= tick.measured_voltage_mv;
            s1_reg.measured_current_ma <= tick.measured_current_ma;
            s1_reg.output_enable       <= tick.output_enable;
            s1_reg.setpoint_changed    <= tick.setpoint_changed;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: loop errors through the deadband, then the four gain products.
    // None of this touches loop state, so it can run ahead of the update.
    // ------------------------------------------------------------------
    err_t        v_err;
    err_t        c_err;
    err_t        v_err_db;
    err_t        c_err_db;
    prod_stage_t s2_next;

    always_comb
    begin
        v_err = err_t'({2'b00, s1_reg.set_voltage_mv}) + err_t'(VOLTAGE_OFFSET_MV)
              - err_t'({2'b00, s1_reg.measured_voltage_mv});
        c_err = err_t'({2'b00, s1_reg.set_current_ma})
              - err_t'({2'b00, s1_reg.measured_current_ma});
        v_err_db = deadband_err(v_err, voltage_deadband_mv_reg);
        c_err_db = deadband_err(c_err, current_deadband_ma_reg);

        s2_next.set_voltage_mv   = s1_reg.set_voltage_mv;
        s2_next.output_enable    = s1_reg.output_enable;
        s2_next.setpoint_changed = s1_reg.setpoint_changed;
        s2_next.v_p              = gain_mul(voltage_kp_reg, v_err_db);
        s2_next.v_i              = gain_mul(voltage_ki_reg, v_err_db);
        s2_next.c_p              = gain_mul(current_kp_reg, c_err_db);
        s2_next.c_i              = gain_mul(current_ki_reg, c_err_db);
    end

    always_ff @(posedge clk)
    begin
        if (load_s2)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: integrator update, CV/CC arbitration, tracking, result
    // ------------------------------------------------------------------
    integ_t voltage_integrator_reg;
    integ_t current_integrator_reg;
    logic   output_was_on_reg;
    logic   last_mode_reg;

    integ_t  voltage_integrator_next;
    integ_t  current_integrator_next;
    logic    output_was_on_next;
    logic    last_mode_next;
    result_t res_next;

    acc_t trim_q;
    acc_t cmax_q;
    acc_t setv_q;
    acc_t vint0;
    acc_t vint1;
    acc_t vcorr;
    acc_t cint1;
    acc_t cdem;
    acc_t ff;
    acc_t ff_head;
    acc_t ctrack;
    acc_t vtrack;
    acc_t final_q;
    logic cv_win;

    always_comb
    begin
        trim_q = mv_to_q(voltage_trim_limit_mv_reg);
        cmax_q = mv_to_q(current_out_max_mv_reg);
        setv_q = mv_to_q(s2_reg.set_voltage_mv);

        // Setpoint change clears the voltage integrator, enabled or not
        vint0 = s2_reg.setpoint_changed ? '0 : acc_t'(voltage_integrator_reg);

        vint1 = clamp_acc(vint0 + acc_t'(s2_reg.v_i), -trim_q, trim_q);
        vcorr = clamp_acc(vint1 + acc_t'(s2_reg.v_p), -trim_q, trim_q);
        cint1 = clamp_acc(acc_t'(current_integrator_reg) + acc_t'(s2_reg.c_i),
                          CMIN_Q, cmax_q);
        cdem  = clamp_acc(cint1 + acc_t'(s2_reg.c_p), CMIN_Q, cmax_q);

        // Voltage demand is setpoint feedforward plus correction
        ff     = setv_q + vcorr;
        cv_win = ff < cdem;
        final_q = cv_win ? ff : cdem;

        // Loser tracks winner: CV leaves headroom on the current loop
        ff_head = ff + HEADROOM_Q;
        ctrack  = (ff_head > cmax_q) ? cmax_q : ff_head;
        vtrack  = clamp_acc(cdem - setv_q, -trim_q, trim_q);

        res_next.voltage_cmd_mv = '0;
        if (final_q > 0)
        begin
            if (|final_q[ACC_W-1:FRAC_BITS+MV_W])
            begin
                res_next.voltage_cmd_mv = '1;
            end
            else
            begin
                res_next.voltage_cmd_mv = final_q[FRAC_BITS+MV_W-1:FRAC_BITS];
            end
        end

        voltage_integrator_next = integ_t'(vint0);
        current_integrator_next = current_integrator_reg;
        output_was_on_next      = output_was_on_reg;
        last_mode_next          = last_mode_reg;
        res_next.drive_enable_changed = 1'b0;

        if (s2_reg.output_enable)
        begin
            output_was_on_next            = 1'b1;
            res_next.drive_enable_changed = !output_was_on_reg;
            last_mode_next                = !cv_win;
            voltage_integrator_next       = integ_t'(cv_win ? vint1 : vtrack);
            current_integrator_next       = integ_t'(cv_win ? ctrack : cint1);
        end
        else
        begin
            res_next.voltage_cmd_mv = '0;
            if (output_was_on_reg)
            begin
                // Off edge: drop both integrators to their idle values
                output_was_on_next            = 1'b0;
                res_next.drive_enable_changed = 1'b1;
                voltage_integrator_next       = '0;
                current_integrator_next       = integ_t'(cmax_q);
            end
        end

        res_next.target_valid    = s2_reg.output_enable;
        res_next.regulation_mode = last_mode_next;
        res_next.drive_enable    = output_was_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_integrator_reg <= '0;
            current_integrator_reg <= CURRENT_INTEG_RST_Q;
            output_was_on_reg      <= 1'b0;
            last_mode_reg          <= 1'b0;
        end
        else if (load_res)
        begin
            voltage_integrator_reg <= voltage_integrator_next;
            current_integrator_reg <= current_integrator_next;
            output_was_on_reg      <= output_was_on_next;
            last_mode_reg          <= last_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid                = res_valid_reg;
    assign result.voltage_cmd_mv       = res_reg.voltage_cmd_mv;
    assign result.target_valid         = res_reg.target_valid;
    assign result.regulation_mode      = res_reg.regulation_mode;
    assign result.drive_enable         = res_reg.drive_enable;
    assign result.drive_enable_changed = res_reg.drive_enable_changed;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A disabled tick always leaves the drive off
    a_disable_drops_drive: assert property (@(posedge clk) disable iff (!rst_n)
        load_res && !s2_reg.output_enable |=> !output_was_on_reg)
        else $error("drive stayed on after a disabled tick");

    // The edge flag reports exactly a change of the drive state
    a_edge_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> res_reg.drive_enable_changed
                     == (output_was_on_reg != $past(output_was_on_reg)))
        else $error("drive edge flag disagrees with drive state");

    // The voltage integrator stays inside the trim window after each update
    a_vint_in_trim: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (acc_t'(voltage_integrator_reg) <= trim_q)
                  && (acc_t'(voltage_integrator_reg) >= -trim_q))
        else $error("voltage integrator outside trim limit");

    // A result marked not valid carries a zero command
    a_idle_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.target_valid |-> res_reg.voltage_cmd_mv == '0)
        else $error("nonzero command on a disabled result");

endmodule

@@ tb/cvcc_regulator_checker.sv @@
`timescale 1ns / 1ps

module cvcc_regulator_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    cvcc_tick_if                            tick,
    cvcc_result_if                          result,
    input  logic                            wr_en,
    input  logic [cvcc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cvcc_pkg::CFG_DATA_W-1:0] wr_data,
    output int                              mismatches,
    output int                              outstanding
);
    import cvcc_pkg::*;

    localparam logic   MODE_CV    = 1'b0;
    localparam logic   MODE_CC    = 1'b1;
    localparam longint Q_ONE      = longint'(1) << FRAC_BITS;
    localparam longint MV_CEILING = (longint'(1) << MV_W) - 1;

    typedef struct packed {
        mv_t  voltage_cmd_mv;
        logic target_valid;
        logic regulation_mode;
        logic drive_enable;
        logic drive_enable_changed;
    } regulator_out_t;

    // Register copies
    gain_t v_kp, v_ki, i_kp, i_ki;
    mv_t   v_db, i_db, v_trim, i_ceiling;

    // Loop state
    logic   out_on;
    logic   cc_mode;
    integ_t v_acc;
    integ_t i_acc;

    regulator_out_t expected_outputs[$];
    int             fail_total = 0;
    int             results_seen;

    assign mismatches = fail_total;

    task automatic report_mismatch(input string msg);
        fail_total++;
        if (fail_total <= 40)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    task automatic pi_update(input longint err_in, input longint band, input longint kp,
                             input longint ki, input longint lo, input longint hi,
                             inout longint acc, output longint demand);
        longint err;
        longint mag;
        err = err_in;
        mag = (err < 0) ? -err : err;
        if (mag < band)
        begin
            err = 0;
        end
        acc    = clip(acc + ki * err, lo, hi);
        demand = clip(kp * err + acc, lo, hi);
    endtask

    task automatic predict_tick(input mv_t set_v, input mv_t set_i, input mv_t meas_v,
                                input mv_t meas_i, input logic en, input logic sp_chg,
                                output regulator_out_t r);
        longint trim_q, ceil_q, floor_q, set_q;
        longint v_work, i_work, v_dem, i_dem, ff, win, whole;
        r = '0;
        if (sp_chg)
        begin
            v_acc = '0;
        end
        v_work = longint'(v_acc);
        i_work = longint'(i_acc);
        if (en)
        begin
            trim_q  = longint'(v_trim) * Q_ONE;
            ceil_q  = longint'(i_ceiling) * Q_ONE;
            floor_q = longint'(CURRENT_OUT_MIN_MV) * Q_ONE;
            set_q   = longint'(set_v) * Q_ONE;
            if (!out_on)
            begin
                out_on = 1'b1;
                r.drive_enable_changed = 1'b1;
            end
            pi_update(longint'(set_v) + VOLTAGE_OFFSET_MV - longint'(meas_v), v_db,
                      v_kp, v_ki, -trim_q, trim_q, v_work, v_dem);
            pi_update(longint'(set_i) - longint'(meas_i), i_db,
                      i_kp, i_ki, floor_q, ceil_q, i_work, i_dem);
            ff = set_q + v_dem;
            if (ff < i_dem)
            begin
                // CV wins; current loop tracks with headroom, capped above only
                win     = ff;
                cc_mode = MODE_CV;
                i_work  = ff + longint'(CV_HEADROOM_MV) * Q_ONE;
                if (i_work > ceil_q)
                begin
                    i_work = ceil_q;
                end
            end
            else
            begin
                win     = i_dem;
                cc_mode = MODE_CC;
                v_work  = clip(win - set_q, -trim_q, trim_q);
            end
            if (win > 0)
            begin
                whole            = win / Q_ONE;
                r.voltage_cmd_mv = (whole > MV_CEILING) ? '1 : mv_t'(whole);
            end
        end
        else if (out_on)
        begin
            out_on = 1'b0;
            r.drive_enable_changed = 1'b1;
            v_work = 0;
            i_work = longint'(i_ceiling) * Q_ONE;
        end
        v_acc = integ_t'(v_work);
        i_acc = integ_t'(i_work);
        r.target_valid    = en;
        r.regulation_mode = cc_mode;
        r.drive_enable    = out_on;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        regulator_out_t seen;
        regulator_out_t oldest;
        regulator_out_t predicted;
        if (!rst_n)
        begin
            v_kp      = VOLTAGE_KP_RST;
            v_ki      = VOLTAGE_KI_RST;
            i_kp      = CURRENT_KP_RST;
            i_ki      = CURRENT_KI_RST;
            v_db      = VOLTAGE_DEADBAND_RST;
            i_db      = CURRENT_DEADBAND_RST;
            v_trim    = VOLTAGE_TRIM_LIMIT_RST;
            i_ceiling = CURRENT_OUT_MAX_RST;
            out_on    = 1'b0;
            cc_mode   = MODE_CV;
            v_acc     = '0;
            i_acc     = integ_t'(longint'(CURRENT_INTEG_RST_MV) * Q_ONE);
            results_seen = 0;
            expected_outputs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (cfg_idx_t'(wr_index))
                    CFG_VOLTAGE_KP:         v_kp      = wr_data;
                    CFG_VOLTAGE_KI:         v_ki      = wr_data;
                    CFG_CURRENT_KP:         i_kp      = wr_data;
                    CFG_CURRENT_KI:         i_ki      = wr_data;
                    CFG_VOLTAGE_DEADBAND:   v_db      = wr_data[MV_W-1:0];
                    CFG_CURRENT_DEADBAND:   i_db      = wr_data[MV_W-1:0];
                    CFG_VOLTAGE_TRIM_LIMIT: v_trim    = wr_data[MV_W-1:0];
                    CFG_CURRENT_OUT_MAX:    i_ceiling = wr_data[MV_W-1:0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                seen.voltage_cmd_mv       = result.voltage_cmd_mv;
                seen.target_valid         = result.target_valid;
                seen.regulation_mode      = result.regulation_mode;
                seen.drive_enable         = result.drive_enable;
                seen.drive_enable_changed = result.drive_enable_changed;
                if (expected_outputs.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end
                else
                begin
                    oldest = expected_outputs.pop_front();
                    if (seen.voltage_cmd_mv !== oldest.voltage_cmd_mv)
                        report_mismatch($sformatf(
                            "result %0d voltage_cmd_mv %0d, expected %0d",
                            results_seen, seen.voltage_cmd_mv, oldest.voltage_cmd_mv));
                    if (seen.target_valid !== oldest.target_valid)
                        report_mismatch($sformatf("result %0d target_valid %b, expected %b",
                            results_seen, seen.target_valid, oldest.target_valid));
                    if (seen.regulation_mode !== oldest.regulation_mode)
                        report_mismatch($sformatf("result %0d regulation_mode %b, expected %b",
                            results_seen, seen.regulation_mode, oldest.regulation_mode));
                    if (seen.drive_enable !== oldest.drive_enable)
                        report_mismatch($sformatf("result %0d drive_enable %b, expected %b",
                            results_seen, seen.drive_enable, oldest.drive_enable));
                    if (seen.drive_enable_changed !== oldest.drive_enable_changed)
                        report_mismatch($sformatf(
                            "result %0d drive_enable_changed %b, expected %b", results_seen,
                            seen.drive_enable_changed, oldest.drive_enable_changed));
                end
                results_seen++;
            end

            if (tick.valid && tick.ready)
            begin
                predict_tick(tick.set_voltage_mv, tick.set_current_ma,
                             tick.measured_voltage_mv, tick.measured_current_ma,
                             tick.output_enable, tick.setpoint_changed, predicted);
                expected_outputs.push_back(predicted);
            end

            outstanding <= expected_outputs.size();
        end
    end

endmodule

@@ tb/cv_cc_dual_pi_regulator_test.sv @@
`timescale 1ns / 1ps

module cv_cc_dual_pi_regulator_test;
    import cvcc_pkg::*;

    localparam int IDLE_PCT         = 27;
    localparam int PHASE_TICKS      = 180;
    localparam int BURST_TICKS      = 40;
    localparam int SINK_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES    = 6;       // three-stage pipeline plus margin
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MV_TOP           = (1 << MV_W) - 1;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    cfg_idx_t              wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    int   mismatches;
    int   outstanding;
    int   ticks_sent;
    int   settings_loaded;
    int   hold_requests;
    logic no_idle;

    // Operating point that the well-formed ticks regulate around
    mv_t  op_set_v;
    mv_t  op_set_i;
    logic op_enable;

    cvcc_tick_if   tick_bus ();
    cvcc_result_if result_bus ();

    cv_cc_dual_pi_regulator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick_bus),
        .result   (result_bus),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    cvcc_regulator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_bus),
        .result      (result_bus),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: count cycles and give up if the run never drains
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("cv_cc_dual_pi_regulator test failed");
        $finish;
    end

    // Result side: drop ready at random, except in the no-idle phase; serve each
    // hold request with one long stall, counted here, so the pipeline fills up
    initial
    begin
        int holds_served;
        holds_served = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                result_bus.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic mv_t near(input mv_t center, input int bias, input int spread);
        int v;
        v = int'($urandom_range(0, 2 * spread)) - spread + bias + int'(center);
        if (v < 0)
        begin
            v = 0;
        end
        if (v > MV_TOP)
        begin
            v = MV_TOP;
        end
        return mv_t'(v);
    endfunction

    // Keep the upper byte random on 16-bit registers; the block must mask it
    function automatic logic [CFG_DATA_W-1:0] pad16(input mv_t v);
        return {8'($urandom), v};
    endfunction

    // Offer one tick and hold it until the transfer; valid stays high on return
    task automatic send_tick(input mv_t sv, input mv_t si, input mv_t mv, input mv_t mi,
                             input logic en, input logic chg);
        tick_bus.valid               <= 1'b1;
        tick_bus.set_voltage_mv      <= sv;
        tick_bus.set_current_ma      <= si;
        tick_bus.measured_voltage_mv <= mv;
        tick_bus.measured_current_ma <= mi;
        tick_bus.output_enable       <= en;
        tick_bus.setpoint_changed    <= chg;
        do @(posedge clk); while (tick_bus.ready !== 1'b1);
        ticks_sent++;
    endtask

    task automatic idle_gap();
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                tick_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        tick_bus.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers in index order, one per cycle
    task automatic load_settings(input logic [CFG_DATA_W-1:0] vals [8]);
        cfg_idx_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            wr_en    <= 1'b1;
            wr_index <= idx;
            wr_data  <= vals[idx];
            @(posedge clk);
            idx = idx.next();
        end
        wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // Mostly ticks around a slowly moving operating point, so both loops settle,
    // trade the win between CV and CC and see enable edges; the rest is noise
    task automatic random_tick();
        int   pick;
        logic chg;
        mv_t  mv;
        mv_t  mi;
        pick = $urandom_range(0, 99);
        chg  = ($urandom_range(0, 99) < 4);
        if ($urandom_range(0, 99) < 3)
        begin
            op_set_v = mv_t'($urandom_range(500, 40000));
            op_set_i = mv_t'($urandom_range(50, 5000));
            chg      = 1'b1;
        end
        if (op_enable)
        begin
            op_enable = ($urandom_range(0, 99) >= 2);
        end
        else
        begin
            op_enable = ($urandom_range(0, 99) < 30);
        end
        if (pick < 75)
        begin
            mv = near(op_set_v, 0, 400);
            // a third of them overload the current loop to force CC
            mi = (pick < 25) ? near(op_set_i, 1000, 600) : near(op_set_i, 0, 300);
            send_tick(op_set_v, op_set_i, mv, mi, op_enable, chg);
        end
        else
        begin
            send_tick(mv_t'($urandom), mv_t'($urandom), mv_t'($urandom), mv_t'($urandom),
                      1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] regs [8];
        int phase;

        rst_n                        <= 1'b0;
        wr_en                        <= 1'b0;
        wr_index                     <= CFG_VOLTAGE_KP;
        wr_data                      <= '0;
        tick_bus.valid               <= 1'b0;
        tick_bus.set_voltage_mv      <= '0;
        tick_bus.set_current_ma      <= '0;
        tick_bus.measured_voltage_mv <= '0;
        tick_bus.measured_current_ma <= '0;
        tick_bus.output_enable       <= 1'b0;
        tick_bus.setpoint_changed    <= 1'b0;
        no_idle                      <= 1'b0;
        hold_requests                <= 0;
        ticks_sent      = 0;
        settings_loaded = 0;
        op_set_v        = mv_t'(12000);
        op_set_i        = mv_t'(2000);
        op_enable       = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at the reset settings
        // disabled before ever being on, then a setpoint clear while off
        idle_gap(); send_tick('0, '0, '0, '0, 1'b0, 1'b0);
        idle_gap(); send_tick('1, '1, '1, '1, 1'b0, 1'b1);
        // rising enable edge, voltage below target: CV
        idle_gap(); send_tick(12000, 3000, 11000, 1000, 1'b1, 1'b0);
        // voltage error right at the deadband, then just inside it
        idle_gap(); send_tick(12000, 3000, 11990, 1000, 1'b1, 1'b0);
        idle_gap(); send_tick(12000, 3000, 11991, 2999, 1'b1, 1'b0);
        // setpoint change while running clears the voltage integrator
        idle_gap(); send_tick(12500, 3000, 12000, 1000, 1'b1, 1'b1);
        // hard overcurrent: current loop drives to its floor, CC wins, target at 0
        repeat (3)
        begin
            idle_gap(); send_tick(12500, 0, 12000, '1, 1'b1, 1'b0);
        end
        // falling edge keeps the CC mode, then stays off
        idle_gap(); send_tick(12500, 0, 12000, '1, 1'b0, 1'b0);
        idle_gap(); send_tick(12500, 0, 12000, '1, 1'b0, 1'b0);
        // field extremes while enabled
        idle_gap(); send_tick('0, '0, '0, '0, 1'b1, 1'b0);
        idle_gap(); send_tick('1, '1, '1, '1, 1'b1, 1'b0);
        idle_gap(); send_tick('1, '1, '0, '0, 1'b1, 1'b0);
        idle_gap(); send_tick('1, '1, '0, '0, 1'b1, 1'b1);
        idle_gap(); send_tick('0, '0, '1, '1, 1'b1, 1'b0);
        idle_gap(); send_tick('0, '0, '1, '1, 1'b0, 1'b1);
        // current limit far away: CV tracking pulls the current integrator down
        repeat (3)
        begin
            idle_gap(); send_tick(5000, '1, 4000, '0, 1'b1, 1'b0);
        end

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                // registers change only with the pipeline empty
                drain();
                case (phase)
                    1:
                    begin
                        regs[CFG_VOLTAGE_KP]         = '1;
                        regs[CFG_VOLTAGE_KI]         = '1;
                        regs[CFG_CURRENT_KP]         = '1;
                        regs[CFG_CURRENT_KI]         = '1;
                        regs[CFG_VOLTAGE_DEADBAND]   = pad16('1);
                        regs[CFG_CURRENT_DEADBAND]   = pad16('1);
                        regs[CFG_VOLTAGE_TRIM_LIMIT] = pad16('1);
                        regs[CFG_CURRENT_OUT_MAX]    = pad16('1);
                    end
                    2:
                    begin
                        regs[CFG_VOLTAGE_KP]         = '0;
                        regs[CFG_VOLTAGE_KI]         = '0;
                        regs[CFG_CURRENT_KP]         = '0;
                        regs[CFG_CURRENT_KI]         = '0;
                        regs[CFG_VOLTAGE_DEADBAND]   = pad16('0);
                        regs[CFG_CURRENT_DEADBAND]   = pad16('0);
                        regs[CFG_VOLTAGE_TRIM_LIMIT] = pad16('0);
                        regs[CFG_CURRENT_OUT_MAX]    = pad16('0);
                    end
                    3:
                    begin
                        regs[CFG_VOLTAGE_KP] = CFG_DATA_W'($urandom_range(0, 1 << 17));
                        regs[CFG_VOLTAGE_KI] = CFG_DATA_W'($urandom_range(0, 1 << 15));
                        regs[CFG_CURRENT_KP] = CFG_DATA_W'($urandom_range(0, 1 << 17));
                        regs[CFG_CURRENT_KI] = CFG_DATA_W'($urandom_range(0, 1 << 17));
                        regs[CFG_VOLTAGE_DEADBAND] = pad16(mv_t'($urandom_range(0, 40)));
                        regs[CFG_CURRENT_DEADBAND] = pad16(mv_t'($urandom_range(0, 20)));
                        regs[CFG_VOLTAGE_TRIM_LIMIT] =
                            pad16(mv_t'($urandom_range(100, 5000)));
                        regs[CFG_CURRENT_OUT_MAX] =
                            pad16(mv_t'($urandom_range(10000, MV_TOP)));
                    end
                    4:
                    begin
                        regs[CFG_VOLTAGE_KP]         = CFG_DATA_W'($urandom);
                        regs[CFG_VOLTAGE_KI]         = CFG_DATA_W'($urandom);
                        regs[CFG_CURRENT_KP]         = CFG_DATA_W'($urandom);
                        regs[CFG_CURRENT_KI]         = CFG_DATA_W'($urandom);
                        regs[CFG_VOLTAGE_DEADBAND]   = CFG_DATA_W'($urandom);
                        regs[CFG_CURRENT_DEADBAND]   = CFG_DATA_W'($urandom);
                        regs[CFG_VOLTAGE_TRIM_LIMIT] = CFG_DATA_W'($urandom);
                        regs[CFG_CURRENT_OUT_MAX]    = CFG_DATA_W'($urandom);
                    end
                    default:
                    begin
                        regs[CFG_VOLTAGE_KP]         = VOLTAGE_KP_RST;
                        regs[CFG_VOLTAGE_KI]         = VOLTAGE_KI_RST;
                        regs[CFG_CURRENT_KP]         = CURRENT_KP_RST;
                        regs[CFG_CURRENT_KI]         = CURRENT_KI_RST;
                        regs[CFG_VOLTAGE_DEADBAND]   = CFG_DATA_W'(VOLTAGE_DEADBAND_RST);
                        regs[CFG_CURRENT_DEADBAND]   = CFG_DATA_W'(CURRENT_DEADBAND_RST);
                        regs[CFG_VOLTAGE_TRIM_LIMIT] = CFG_DATA_W'(VOLTAGE_TRIM_LIMIT_RST);
                        regs[CFG_CURRENT_OUT_MAX]    = CFG_DATA_W'(CURRENT_OUT_MAX_RST);
                    end
                endcase
                // last phase runs with both sides streaming, no idle cycles
                no_idle <= (phase == 5);
                load_settings(regs);
            end

            if (phase == 3)
            begin
                // stall the result side and keep offering ticks back to back
                hold_requests <= hold_requests + 1;
                repeat (BURST_TICKS) random_tick();
            end

            repeat (PHASE_TICKS)
            begin
                idle_gap();
                random_tick();
            end
        end

        drain();

        $display("Ran %0d ticks across the reset settings and %0d register loads", ticks_sent,
                 settings_loaded);
        $display("(all-ones, all-zeros, mid-range, random, defaults), with a %0d-cycle stall.",
                 SINK_HOLD_CYCLES);
        if (mismatches == 0)
        begin
            $display("cv_cc_dual_pi_regulator test passed");
        end
        else
        begin
            $display("cv_cc_dual_pi_regulator test failed");
        end
        $finish;
    end

endmodule

@@ cv_cc_dual_pi_regulator.f @@
hw/rtl/cvcc_pkg.sv
hw/rtl/cvcc_tick_if.sv
hw/rtl/cvcc_result_if.sv
hw/rtl/cv_cc_dual_pi_regulator.sv
tb/cvcc_regulator_checker.sv
tb/cv_cc_dual_pi_regulator_test.sv
